@@ rtl/cbss_pkg.sv @@
// ----------------------------------------------------------------------------
// cbss_pkg
// Types and constants shared by the spline sampler modules.
// ----------------------------------------------------------------------------
package cbss_pkg;

	localparam int T_W       = 17;            // t and u in Q16, up to 1.0
	localparam int UU_W      = 33;            // u*u and t*t, up to 2^32
	localparam int WT_W      = 33;            // rounded weights in Q32
	localparam int MA_W      = 34;            // signed weight-side operand
	localparam int DIV_CNT_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 6;

	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOSED_LOOP = 1'b0,
		CFG_SEGMENTS    = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_UU, OP_TT, OP_W0, OP_W1, OP_W2, OP_W3,
		OP_MX0, OP_MX1, OP_MX2, OP_MX3,
		OP_MY0, OP_MY1, OP_MY2, OP_MY3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_FIRST, ST_SEG, ST_STEP, ST_CALC, ST_DRAIN, ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic seg_load;
		logic seg_sel;
		logic t_step;
		logic op_valid;
		op_t  op;
		logic emit;
		logic emit_first;
		logic emit_last;
		logic store_first;
		logic store_prev;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

@@ rtl/cbss_if.sv @@
// ----------------------------------------------------------------------------
// cbss_if
// Channel interfaces for control points and curve samples.
// ----------------------------------------------------------------------------
interface cbss_pt_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] arrive_x;
	logic signed [COORD_BITS-1:0] arrive_y;
	logic signed [COORD_BITS-1:0] leave_x;
	logic signed [COORD_BITS-1:0] leave_y;
	logic                         final_point;

	modport source (output valid, point_x, point_y, arrive_x, arrive_y, leave_x, leave_y,
		final_point, input ready);
	modport sink (input valid, point_x, point_y, arrive_x, arrive_y, leave_x, leave_y,
		final_point, output ready);
endinterface

interface cbss_smp_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] sample_x;
	logic signed [COORD_BITS-1:0] sample_y;
	logic                         last_of_run;

	modport source (output valid, sample_x, sample_y, last_of_run, input ready);
	modport sink (input valid, sample_x, sample_y, last_of_run, output ready);
endinterface

@@ rtl/cbss_div.sv @@
// ----------------------------------------------------------------------------
// cbss_div
// Restoring divider: 2^16 / steps, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbss_div
	import cbss_pkg::*;
#(
	parameter int SW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SW-1:0]        divisor,
	output logic                 done,
	output logic [T_W-1:0]       quo,
	output logic [SW-1:0]        rem
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SW-1:0]        rem_q;
	logic [T_W-1:0]       quo_q;
	logic [SW:0]          trial;
	logic                 ge;

	always_comb begin
		trial = {rem_q, (cnt_q == DIV_CNT_W'(T_W - 1))};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(T_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? SW'(trial - {1'b0, divisor}) : SW'(trial);
			quo_q <= {quo_q[T_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ rtl/cbss_dp.sv @@
// ----------------------------------------------------------------------------
// cbss_dp
// Datapath: point storage, T stepping, shared multiplier, accumulator, output.
// ----------------------------------------------------------------------------
module cbss_dp
	import cbss_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int SW         = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  logic [SW-1:0]                steps,
	input  logic signed [COORD_BITS-1:0] pt_x,
	input  logic signed [COORD_BITS-1:0] pt_y,
	input  logic signed [COORD_BITS-1:0] arr_x,
	input  logic signed [COORD_BITS-1:0] arr_y,
	input  logic signed [COORD_BITS-1:0] lea_x,
	input  logic signed [COORD_BITS-1:0] lea_y,
	cbss_smp_if.source                   samples
);

	localparam int CB = COORD_BITS;
	localparam int CP = CB + 1;
	localparam int MB = (CP > 19) ? CP : 19;
	localparam int PW = MA_W + MB;
	localparam int AW = PW + 2;
	localparam int RW = AW - 32;
	localparam logic signed [AW-1:0] HALF = AW'(1) << 31;

	logic signed [CB-1:0] in_lx_q, in_ly_q, in_ax_q, in_ay_q, in_ex_q, in_ey_q;
	logic signed [CB-1:0] first_lx_q, first_ly_q, first_ax_q, first_ay_q;
	logic signed [CB-1:0] prev_lx_q, prev_ly_q, prev_ex_q, prev_ey_q;
	logic signed [CP-1:0] px_q [4];
	logic signed [CP-1:0] py_q [4];

	logic                 div_done;
	logic [T_W-1:0]       q0;
	logic [SW-1:0]        r0;
	logic [T_W-1:0]       t_q;
	logic [SW-1:0]        racc_q;
	logic [SW:0]          rsum;
	logic [T_W-1:0]       u;
	logic [T_W:0]         t3, u3;

	logic [UU_W-1:0]      uu_q, tt_q;
	logic [WT_W-1:0]      w_q [4];
	logic signed [MA_W-1:0] a_op;
	logic signed [MB-1:0]   b_op;
	logic signed [PW-1:0]   prod_s1;
	op_t                    op_s1;
	logic                   opv_s1;
	logic signed [AW-1:0]   acc_q, acc_base, acc_next, rnd;
	logic [WT_W-1:0]        wr;

	logic                 out_valid_q;
	logic signed [CB-1:0] out_x_q, out_y_q, res_x_q, res_y_q;
	logic                 out_last_q;

	function automatic logic signed [CB-1:0] sat(input logic signed [AW-1:0] r);
		logic signed [RW-1:0] v;
		v = r[AW-1:32];
		if (&v[RW-1:CB-1] || ~|v[RW-1:CB-1])
			return v[CB-1:0];
		else
			return v[RW-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
	endfunction

	cbss_div #(.SW(SW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (steps),
		.done    (div_done),
		.quo     (q0),
		.rem     (r0)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_lx_q <= pt_x;
			in_ly_q <= pt_y;
			in_ax_q <= arr_x;
			in_ay_q <= arr_y;
			in_ex_q <= lea_x;
			in_ey_q <= lea_y;
		end
		if (cmd.store_first) begin
			first_lx_q <= in_lx_q;
			first_ly_q <= in_ly_q;
			first_ax_q <= in_ax_q;
			first_ay_q <= in_ay_q;
		end
		if (cmd.store_prev) begin
			prev_lx_q <= in_lx_q;
			prev_ly_q <= in_ly_q;
			prev_ex_q <= in_ex_q;
			prev_ey_q <= in_ey_q;
		end
		if (cmd.seg_load) begin
			if (!cmd.seg_sel) begin
				px_q[0] <= CP'(prev_lx_q);
				px_q[1] <= CP'(prev_lx_q) + CP'(prev_ex_q);
				px_q[2] <= CP'(in_lx_q) + CP'(in_ax_q);
				px_q[3] <= CP'(in_lx_q);
				py_q[0] <= CP'(prev_ly_q);
				py_q[1] <= CP'(prev_ly_q) + CP'(prev_ey_q);
				py_q[2] <= CP'(in_ly_q) + CP'(in_ay_q);
				py_q[3] <= CP'(in_ly_q);
			end else begin
				px_q[0] <= CP'(in_lx_q);
				px_q[1] <= CP'(in_lx_q) + CP'(in_ex_q);
				px_q[2] <= CP'(first_lx_q) + CP'(first_ax_q);
				px_q[3] <= CP'(first_lx_q);
				py_q[0] <= CP'(in_ly_q);
				py_q[1] <= CP'(in_ly_q) + CP'(in_ey_q);
				py_q[2] <= CP'(first_ly_q) + CP'(first_ay_q);
				py_q[3] <= CP'(first_ly_q);
			end
		end
	end

	// t advances by q0 plus a carry from the remainder
	assign rsum = {1'b0, racc_q} + {1'b0, r0};
	assign u    = T_ONE - t_q;
	assign t3   = ({1'b0, t_q} << 1) + {1'b0, t_q};
	assign u3   = ({1'b0, u} << 1) + {1'b0, u};

	always_ff @(posedge clk) begin
		if (cmd.seg_load) begin
			t_q    <= '0;
			racc_q <= '0;
		end else if (cmd.t_step) begin
			if (rsum >= {1'b0, steps}) begin
				racc_q <= SW'(rsum - {1'b0, steps});
				t_q    <= t_q + q0 + 1'b1;
			end else begin
				racc_q <= SW'(rsum);
				t_q    <= t_q + q0;
			end
		end
	end

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.op)
			OP_UU:   begin a_op = MA_W'(u);    b_op = MB'(u);     end
			OP_TT:   begin a_op = MA_W'(t_q);  b_op = MB'(t_q);   end
			OP_W0:   begin a_op = MA_W'(uu_q); b_op = MB'(u);     end
			OP_W1:   begin a_op = MA_W'(uu_q); b_op = MB'(t3);    end
			OP_W2:   begin a_op = MA_W'(tt_q); b_op = MB'(u3);    end
			OP_W3:   begin a_op = MA_W'(tt_q); b_op = MB'(t_q);   end
			OP_MX0:  begin a_op = MA_W'(w_q[0]); b_op = MB'(px_q[0]); end
			OP_MX1:  begin a_op = MA_W'(w_q[1]); b_op = MB'(px_q[1]); end
			OP_MX2:  begin a_op = MA_W'(w_q[2]); b_op = MB'(px_q[2]); end
			OP_MX3:  begin a_op = MA_W'(w_q[3]); b_op = MB'(px_q[3]); end
			OP_MY0:  begin a_op = MA_W'(w_q[0]); b_op = MB'(py_q[0]); end
			OP_MY1:  begin a_op = MA_W'(w_q[1]); b_op = MB'(py_q[1]); end
			OP_MY2:  begin a_op = MA_W'(w_q[2]); b_op = MB'(py_q[2]); end
			OP_MY3:  begin a_op = MA_W'(w_q[3]); b_op = MB'(py_q[3]); end
			default: begin a_op = '0; b_op = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opv_s1 <= 1'b0;
		end else begin
			opv_s1 <= cmd.op_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_op * b_op;
		op_s1   <= cmd.op;
	end

	// weight rounding to Q32 and accumulate with rounding to Q0
	always_comb begin
		wr       = prod_s1[WT_W+15:16] + WT_W'(prod_s1[15]);
		acc_base = (op_s1 == OP_MX0 || op_s1 == OP_MY0) ? '0 : acc_q;
		acc_next = acc_base + AW'(prod_s1);
		rnd      = (acc_next + HALF) >>> 32;
	end

	always_ff @(posedge clk) begin
		if (opv_s1) begin
			case (op_s1)
				OP_UU:   uu_q   <= prod_s1[UU_W-1:0];
				OP_TT:   tt_q   <= prod_s1[UU_W-1:0];
				OP_W0:   w_q[0] <= wr;
				OP_W1:   w_q[1] <= wr;
				OP_W2:   w_q[2] <= wr;
				OP_W3:   w_q[3] <= wr;
				OP_MX3: begin
					acc_q   <= acc_next;
					res_x_q <= sat(rnd << 32);
				end
				OP_MY3: begin
					acc_q   <= acc_next;
					res_y_q <= sat(rnd << 32);
				end
				default: acc_q <= acc_next;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (samples.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q    <= cmd.emit_first ? in_lx_q : res_x_q;
			out_y_q    <= cmd.emit_first ? in_ly_q : res_y_q;
			out_last_q <= cmd.emit_last;
		end
	end

	assign samples.valid       = out_valid_q;
	assign samples.sample_x    = out_x_q;
	assign samples.sample_y    = out_y_q;
	assign samples.last_of_run = out_last_q;

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || samples.ready;

endmodule

@@ rtl/cbss_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbss_ctrl
// Controller: sequences division, segments, samples and multiply ops.
// ----------------------------------------------------------------------------
module cbss_ctrl
	import cbss_pkg::*;
#(
	parameter int SW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          in_final,
	input  logic          closed,
	input  logic [SW-1:0] steps,
	input  status_t       status,
	output cmd_t          cmd,
	output logic          idle
);

	state_t        state_q, state_d;
	logic          fin_q, have_first_q, seg_q;
	logic [SW-1:0] k_q;
	op_t           op_q;
	logic [SW-1:0] cnt;
	logic          more;
	logic          seg_end;
	logic          last;

	always_comb begin
		more    = fin_q && closed && (steps != SW'(1));
		cnt     = seg_q ? steps - 1'b1 : steps;
		seg_end = k_q == cnt;
		last    = seg_end && (seg_q || !more);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_DIV;
			ST_DIV: begin
				if (status.div_done) begin
					if (have_first_q)
						state_d = ST_SEG;
					else
						state_d = fin_q ? ST_IDLE : ST_FIRST;
				end
			end
			ST_FIRST: if (status.out_free) state_d = ST_IDLE;
			ST_SEG:   state_d = ST_STEP;
			ST_STEP:  state_d = ST_CALC;
			ST_CALC:  if (op_q == OP_MY3) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) begin
					if (!seg_end)
						state_d = ST_STEP;
					else
						state_d = (!seg_q && more) ? ST_SEG : ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in   = in_fire;
				cmd.div_start = in_fire;
			end
			ST_FIRST: begin
				cmd.emit        = status.out_free;
				cmd.emit_first  = 1'b1;
				cmd.emit_last   = 1'b1;
				cmd.store_first = status.out_free;
				cmd.store_prev  = status.out_free;
			end
			ST_SEG: begin
				cmd.seg_load = 1'b1;
				cmd.seg_sel  = seg_q;
			end
			ST_STEP:  cmd.t_step = 1'b1;
			ST_CALC: begin
				cmd.op_valid = 1'b1;
				cmd.op       = op_q;
			end
			ST_EMIT: begin
				cmd.emit       = status.out_free;
				cmd.emit_last  = last;
				cmd.store_prev = status.out_free && seg_end && !seg_q && !fin_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fin_q        <= 1'b0;
			have_first_q <= 1'b0;
			seg_q        <= 1'b0;
			k_q          <= '0;
			op_q         <= OP_UU;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						fin_q <= in_final;
						seg_q <= 1'b0;
					end
				end
				ST_FIRST: if (status.out_free) have_first_q <= 1'b1;
				ST_SEG:   k_q <= '0;
				ST_STEP: begin
					k_q  <= k_q + 1'b1;
					op_q <= OP_UU;
				end
				ST_CALC:  if (op_q != OP_MY3) op_q <= op_t'(op_q + 1'b1);
				ST_EMIT: begin
					if (status.out_free && seg_end) begin
						if (!seg_q && more)
							seg_q <= 1'b1;
						else if (fin_q)
							have_first_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/cubic_bezier_spline_sampler.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_spline_sampler
// Samples a cubic Bezier spline from a stream of control points.
//
//   channel   dir   payload
//   points    in    point/arrive/leave x,y, final_point
//   samples   out   sample_x, sample_y, last_of_run
//   cfg       in    cfg_wr_en, cfg_index, cfg_data
//
// One item at a time: setup runs the 2^16/steps divider, then each sample
// is computed by the 14 ops on the one shared multiplier. Reset clears
// control state only.
// A stalled output holds the sequencer in its emit or first-point step.
// ----------------------------------------------------------------------------
module cubic_bezier_spline_sampler
	import cbss_pkg::*;
#(
	parameter int MAX_STEPS  = 32,
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	cbss_pt_if.sink              points,
	cbss_smp_if.source           samples
);

	localparam int SW = $clog2(MAX_STEPS + 1);

	logic                 closed_q;
	logic [CFG_DAT_W-1:0] spc_q;
	logic [SW-1:0]        steps;
	logic                 idle;
	logic                 in_fire;
	cmd_t                 cmd;
	status_t              status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			spc_q    <= CFG_DAT_W'(8);
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CLOSED_LOOP: closed_q <= cfg_data[0];
				CFG_SEGMENTS:    spc_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (spc_q == '0)
			steps = SW'(1);
		else if (spc_q > CFG_DAT_W'(MAX_STEPS))
			steps = SW'(MAX_STEPS);
		else
			steps = SW'(spc_q);
	end

	assign points.ready = idle;
	assign in_fire      = points.valid && idle;

	cbss_ctrl #(.SW(SW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_final (points.final_point),
		.closed   (closed_q),
		.steps    (steps),
		.status   (status),
		.cmd      (cmd),
		.idle     (idle)
	);

	cbss_dp #(.COORD_BITS(COORD_BITS), .SW(SW)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.steps   (steps),
		.pt_x    (points.point_x),
		.pt_y    (points.point_y),
		.arr_x   (points.arrive_x),
		.arr_y   (points.arrive_y),
		.lea_x   (points.leave_x),
		.lea_y   (points.leave_y),
		.samples (samples)
	);

endmodule

@@ test/cubic_bezier_spline_sampler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_spline_sampler_tb
// Drives control points through the spline sampler with random idling on
// both channels and checks every sample against a bit-exact Bezier predictor.
// ----------------------------------------------------------------------------
module cubic_bezier_spline_sampler_tb
	import cbss_pkg::*;
;

	localparam int CB = 16;
	localparam int MAX_STEPS = 32;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic signed [CB-1:0] px, py, ax, ay, lx, ly;
		logic                 fin;
	} point_t;

	typedef struct packed {
		logic signed [CB-1:0] sx, sy;
		logic                 last;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CLOSED_LOOP;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	cbss_pt_if  #(.COORD_BITS(CB)) points ();
	cbss_smp_if #(.COORD_BITS(CB)) samples ();

	cubic_bezier_spline_sampler #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(CB)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .points(points.sink), .samples(samples.source)
	);

	always #1 clk = ~clk;

	point_t  pending_points[$];
	sample_t expected_samples[$];
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      failed = 0;
	int      quiet_cycles = 0;
	bit      sent_flag = 0;

	// predictor state
	bit     closed_cfg;
	int     seg_cfg;
	bit     have_first;
	longint first_loc[2], first_arr[2], prev_loc[2], prev_lea[2];

	function automatic logic signed [CB-1:0] clamp_coord(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[CB-1:0];
	endfunction

	function automatic longint round_q32(longint s);
		longint v;
		v = s + (longint'(1) << 31);
		return v >>> 32;
	endfunction

	task automatic push_segment(longint a_loc[2], longint a_lea[2], longint b_loc[2],
		longint b_arr[2], int steps, int count);
		longint t, u, s;
		longint w[4];
		longint p[4];
		sample_t r;
		logic signed [CB-1:0] c_out[2];
		for (int k = 1; k <= count; k++) begin
			t = (longint'(k) << 16) / steps;
			u = 65536 - t;
			w[0] = (u * u * u + 32768) >>> 16;
			w[1] = (3 * u * u * t + 32768) >>> 16;
			w[2] = (3 * u * t * t + 32768) >>> 16;
			w[3] = (t * t * t + 32768) >>> 16;
			for (int c = 0; c < 2; c++) begin
				p[0] = a_loc[c];
				p[1] = a_loc[c] + a_lea[c];
				p[2] = b_loc[c] + b_arr[c];
				p[3] = b_loc[c];
				s = 0;
				for (int i = 0; i < 4; i++) s += w[i] * p[i];
				c_out[c] = clamp_coord(round_q32(s));
			end
			r.sx = c_out[0];
			r.sy = c_out[1];
			r.last = 1'b0;
			expected_samples.push_back(r);
		end
	endtask

	task automatic predict_samples(point_t pt);
		longint loc[2], arr[2], lea[2];
		int steps, n0;
		sample_t r;
		loc[0] = pt.px; loc[1] = pt.py;
		arr[0] = pt.ax; arr[1] = pt.ay;
		lea[0] = pt.lx; lea[1] = pt.ly;
		steps = (seg_cfg < 1) ? 1 : (seg_cfg > MAX_STEPS ? MAX_STEPS : seg_cfg);
		n0 = expected_samples.size();
		if (!have_first) begin
			if (pt.fin) return;
			have_first = 1;
			first_loc = loc; first_arr = arr; prev_loc = loc; prev_lea = lea;
			r.sx = pt.px; r.sy = pt.py; r.last = 1'b1;
			expected_samples.push_back(r);
			return;
		end
		push_segment(prev_loc, prev_lea, loc, arr, steps, steps);
		if (pt.fin) begin
			if (closed_cfg) push_segment(loc, lea, first_loc, first_arr, steps, steps - 1);
			have_first = 0;
		end else begin
			prev_loc = loc; prev_lea = lea;
		end
		if (expected_samples.size() > n0)
			expected_samples[expected_samples.size() - 1].last = 1'b1;
	endtask

	logic pt_accept;
	assign pt_accept = points.valid && points.ready;

	initial begin
		points.valid = 1'b0;
		{points.point_x, points.point_y, points.arrive_x, points.arrive_y} = '0;
		{points.leave_x, points.leave_y, points.final_point} = '0;
		samples.ready = 1'b0;
	end

	// driver
	always @(negedge clk) begin
		point_t nxt;
		if (arst_n) begin
			if (!points.valid || sent_flag) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_points[0];
					points.valid <= 1'b1;
					points.point_x <= nxt.px; points.point_y <= nxt.py;
					points.arrive_x <= nxt.ax; points.arrive_y <= nxt.ay;
					points.leave_x <= nxt.lx; points.leave_y <= nxt.ly;
					points.final_point <= nxt.fin;
				end else begin
					points.valid <= 1'b0;
				end
			end
			samples.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// acceptance at the rising edge: predict and pop
	always @(posedge clk) begin
		point_t pt;
		sent_flag <= 1'b0;
		if (arst_n && pt_accept) begin
			pt = pending_points.pop_front();
			predict_samples(pt);
			sent_flag <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		sample_t exp_s;
		if (arst_n) begin
			if (samples.valid && samples.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample x=%0d y=%0d last=%0b", $time,
						samples.sample_x, samples.sample_y, samples.last_of_run);
					failed = 1;
				end else begin
					exp_s = expected_samples.pop_front();
					if (samples.sample_x !== exp_s.sx)
						$display("%0t: sample_x expected %0d actual %0d", $time, exp_s.sx,
							samples.sample_x);
					if (samples.sample_y !== exp_s.sy)
						$display("%0t: sample_y expected %0d actual %0d", $time, exp_s.sy,
							samples.sample_y);
					if (samples.last_of_run !== exp_s.last)
						$display("%0t: last_of_run expected %0b actual %0b", $time, exp_s.last,
							samples.last_of_run);
					if (samples.sample_x !== exp_s.sx || samples.sample_y !== exp_s.sy ||
						samples.last_of_run !== exp_s.last)
						failed = 1;
				end
			end
			if ((samples.valid && samples.ready) || pt_accept) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic logic signed [CB-1:0] rand_coord();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return CB'($urandom);
			default: return CB'($urandom_range(2000)) - CB'(1000);
		endcase
	endfunction

	function automatic point_t rand_point(bit fin);
		point_t p;
		p.px = rand_coord(); p.py = rand_coord();
		p.ax = rand_coord(); p.ay = rand_coord();
		p.lx = rand_coord(); p.ly = rand_coord();
		p.fin = fin;
		return p;
	endfunction

	task automatic write_reg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_CLOSED_LOOP) closed_cfg = value[0];
		else seg_cfg = value & 63;
	endtask

	task automatic wait_drained();
		while (pending_points.size() > 0 || points.valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (2400) @(posedge clk);
	endtask

	task automatic add_splines(int n_items);
		int len;
		while (n_items > 0) begin
			if ($urandom_range(9) == 0) begin
				pending_points.push_back(rand_point($urandom_range(1)));
				n_items--;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) pending_points.push_back(rand_point(i == len - 1));
				n_items -= len;
			end
		end
	endtask

	initial begin
		point_t p;
		int seg_choices[6];
		seg_choices = '{0, 1, 2, 32, 5, 63};
		closed_cfg = 0; seg_cfg = 8; have_first = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, lone final point, open and closed loops
		write_reg(CFG_CLOSED_LOOP, 1);
		write_reg(CFG_SEGMENTS, 3);
		p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0};
		pending_points.push_back(p);
		p = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0};
		pending_points.push_back(p);
		p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1};
		pending_points.push_back(p);
		pending_points.push_back(rand_point(1));
		pending_points.push_back(point_t'(0));
		pending_points.push_back(rand_point(1));
		wait_drained();
		write_reg(CFG_SEGMENTS, 0);
		for (int i = 0; i < 3; i++) pending_points.push_back(rand_point(i == 2));
		wait_drained();
		write_reg(CFG_CLOSED_LOOP, 0);
		write_reg(CFG_SEGMENTS, 32);
		for (int i = 0; i < 3; i++) pending_points.push_back(rand_point(i == 2));
		wait_drained();

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 19 : (ph < 8) ? 72 : 0;
			recv_idle_pct = (ph < 4) ? 72 : (ph < 8) ? 19 : 0;
			write_reg(CFG_CLOSED_LOOP, $urandom_range(1));
			write_reg(CFG_SEGMENTS, (ph % 3 == 0) ? seg_choices[ph % 6] : $urandom_range(1, 6));
			add_splines(33);
			wait_drained();
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		if (failed == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
